### rtl/core/kco_pkg.sv
// Package: shared constants and types for the keyed cache with oldest eviction.
`timescale 1ns / 1ps
`default_nettype none
package kco_pkg;

  localparam int ENTRIES   = 8;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TYPE_W    = 4;
  localparam int KEY_W     = 64;
  localparam int TIME_W    = 32;
  localparam int QUAL_W    = 64;

  localparam logic [TYPE_W-1:0] ETH_TYPE_RESET = TYPE_W'(1);
  localparam logic              CMD_ADD        = 1'b0;
  localparam logic              CMD_LOOKUP     = 1'b1;
  localparam logic [IDX_W-1:0]  IDX_LAST       = IDX_W'(ENTRIES - 1);

  typedef struct packed {
    logic [TYPE_W-1:0] conn_type;
    logic [KEY_W-1:0]  name_key;
    logic [TIME_W-1:0] upd_time;
    logic [QUAL_W-1:0] quality;
  } entry_t;

  typedef struct packed {
    logic match;
    logic older;
  } cmp_res_t;

  typedef struct packed {
    logic             clr_en;
    logic [IDX_W-1:0] clr_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
  } store_ctl_t;

endpackage
`default_nettype wire

### rtl/core/kco_store.sv
// Record store: per-slot valid flags and record registers, one read and one write port.
`timescale 1ns / 1ps
`default_nettype none
module kco_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire kco_pkg::store_ctl_t       ctl,
  input  wire kco_pkg::entry_t           wr_entry,
  input  wire logic [kco_pkg::IDX_W-1:0] rd_idx,
  output kco_pkg::entry_t                rd_entry,
  output logic                           rd_valid
);
  import kco_pkg::*;

  entry_t             entry_r [ENTRIES];
  logic [ENTRIES-1:0] valid_r;
  logic [ENTRIES-1:0] valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (ctl.clr_en) begin
      valid_nxt[ctl.clr_idx] = 1'b0;
    end
    if (ctl.wr_en) begin
      valid_nxt[ctl.wr_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      entry_r[ctl.wr_idx] <= wr_entry;
    end
  end

  assign rd_entry = entry_r[rd_idx];
  assign rd_valid = valid_r[rd_idx];

`ifndef ASSERT_OFF
  a_wr_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |=> valid_r[$past(ctl.wr_idx)])
    else $error("written slot not valid");
  a_clr_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.clr_en && !ctl.wr_en) |=> !valid_r[$past(ctl.clr_idx)])
    else $error("cleared slot still valid");
  a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.clr_en |=> $countones(valid_r & ~$past(valid_r)) <= 1)
    else $error("more than one slot filled at once");
`endif

endmodule
`default_nettype wire

### rtl/core/kco_cmp.sv
// Shared compare unit: key match and timestamp age test for one record.
`timescale 1ns / 1ps
`default_nettype none
module kco_cmp (
  input  wire kco_pkg::entry_t            entry,
  input  wire logic                       entry_valid,
  input  wire logic [kco_pkg::TYPE_W-1:0] conn_type,
  input  wire logic [kco_pkg::KEY_W-1:0]  name_key,
  input  wire logic [kco_pkg::TIME_W-1:0] best_time,
  output kco_pkg::cmp_res_t               res
);
  import kco_pkg::*;

  always_comb begin
    res.match = entry_valid && (entry.conn_type == conn_type) && (entry.name_key == name_key);
    res.older = entry.upd_time < best_time;
  end

endmodule
`default_nettype wire

### rtl/core/keyed_cache_oldest_eviction.sv
// Top level: command sequencer walking the record store through the shared compare unit.
// After acceptance a command scans all ENTRIES slots, updates in the finish state, then strobes its result.
// A new command is taken only while idle; busy is high for the scan of all
// ENTRIES slots plus the finish (update) state, set by the single store read port.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Reset (rst_n low, synchronous): all slots invalid, ethernet type code 1.
`timescale 1ns / 1ps
`default_nettype none
module keyed_cache_oldest_eviction (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_cmd,
  input  wire logic [kco_pkg::TYPE_W-1:0] in_conn_type,
  input  wire logic [kco_pkg::KEY_W-1:0]  in_name_key,
  input  wire logic                       in_name_empty,
  input  wire logic [kco_pkg::TIME_W-1:0] in_update_time,
  input  wire logic [kco_pkg::QUAL_W-1:0] in_quality_in,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic [kco_pkg::QUAL_W-1:0]      out_quality_out,
  output logic                            out_stored,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [kco_pkg::TYPE_W-1:0] cfg_data
);
  import kco_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [TYPE_W-1:0] eth_r;

  logic              cmd_r, empty_r;
  logic [TYPE_W-1:0] type_r;
  logic [KEY_W-1:0]  key_r;
  logic [TIME_W-1:0] time_r;
  logic [QUAL_W-1:0] qin_r;

  logic              match_r, match_nxt;
  logic [IDX_W-1:0]  match_idx_r, match_idx_nxt;
  logic              free_r, free_nxt;
  logic [IDX_W-1:0]  free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]  old_idx_r, old_idx_nxt;
  logic [TIME_W-1:0] old_time_r, old_time_nxt;
  logic [QUAL_W-1:0] qual_r, qual_nxt;

  logic              out_valid_r, out_hit_r, out_stored_r;
  logic [QUAL_W-1:0] out_quality_r;

  entry_t            rd_entry;
  entry_t            wr_entry;
  logic              rd_valid;
  cmp_res_t          cmp;
  store_ctl_t        ctl;

  logic              accept;
  logic              refuse;
  logic              do_store;
  logic [IDX_W-1:0]  slot;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  kco_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .wr_entry (wr_entry),
    .rd_idx   (cnt_r),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  kco_cmp u_cmp (
    .entry       (rd_entry),
    .entry_valid (rd_valid),
    .conn_type   (type_r),
    .name_key    (key_r),
    .best_time   (old_time_r),
    .res         (cmp)
  );

  always_comb begin
    refuse   = (cmd_r == CMD_ADD) && empty_r && (type_r != eth_r);
    do_store = (state_r == ST_FINISH) && (cmd_r == CMD_ADD) && !refuse;
    if (match_r && free_r) begin
      slot = (free_idx_r < match_idx_r) ? free_idx_r : match_idx_r;
    end else if (match_r) begin
      slot = match_idx_r;
    end else if (free_r) begin
      slot = free_idx_r;
    end else begin
      slot = old_idx_r;
    end
    ctl.clr_en  = do_store && match_r;
    ctl.clr_idx = match_idx_r;
    ctl.wr_en   = do_store;
    ctl.wr_idx  = slot;
    wr_entry.conn_type = type_r;
    wr_entry.name_key  = key_r;
    wr_entry.upd_time  = time_r;
    wr_entry.quality   = qin_r;
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    match_nxt     = match_r;
    match_idx_nxt = match_idx_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    old_idx_nxt   = old_idx_r;
    old_time_nxt  = old_time_r;
    qual_nxt      = qual_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_SCAN;
          cnt_nxt   = '0;
          match_nxt = 1'b0;
          free_nxt  = 1'b0;
        end
      end
      ST_SCAN: begin
        if (cmp.match && !match_r) begin
          match_nxt     = 1'b1;
          match_idx_nxt = cnt_r;
          qual_nxt      = rd_entry.quality;
        end
        if (!rd_valid && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = cnt_r;
        end
        if (rd_valid && ((cnt_r == '0) || cmp.older)) begin
          old_idx_nxt  = cnt_r;
          old_time_nxt = rd_entry.upd_time;
        end
        if (cnt_r == IDX_LAST) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      ST_FINISH: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      eth_r       <= ETH_TYPE_RESET;
      out_valid_r <= 1'b0;
      match_r     <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      match_r     <= match_nxt;
      free_r      <= free_nxt;
      out_valid_r <= (state_r == ST_FINISH);
      if (cfg_valid && cfg_ready) begin
        eth_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    match_idx_r <= match_idx_nxt;
    free_idx_r  <= free_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_time_r  <= old_time_nxt;
    qual_r      <= qual_nxt;
    if (accept) begin
      cmd_r   <= in_cmd;
      type_r  <= in_conn_type;
      key_r   <= in_name_key;
      empty_r <= in_name_empty;
      time_r  <= in_update_time;
      qin_r   <= in_quality_in;
    end
    if (state_r == ST_FINISH) begin
      out_hit_r     <= (cmd_r == CMD_LOOKUP) && match_r;
      out_quality_r <= ((cmd_r == CMD_LOOKUP) && match_r) ? qual_r : '0;
      out_stored_r  <= do_store;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_quality_out = out_quality_r;
  assign out_stored      = out_stored_r;

`ifndef ASSERT_OFF
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("not busy after accepting a command");
  a_hit_xor_store: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_stored))
    else $error("hit and stored both set");
  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_FINISH))
    else $error("result strobe without finished command");
  a_no_store_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_en) |-> (cmd_r == CMD_ADD))
    else $error("store written on lookup");
`endif

endmodule
`default_nettype wire

### dv/tb_keyed_cache_oldest_eviction.sv
// Testbench for keyed_cache_oldest_eviction: directed and random commands checked against a predictor.
`timescale 1ns / 1ps
module tb_keyed_cache_oldest_eviction;
  import kco_pkg::*;

  localparam int LATENCY    = ENTRIES + 2;
  localparam int IDLE_LIMIT = 500;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 200;

  typedef struct packed {
    logic              hit;
    logic [QUAL_W-1:0] quality;
    logic              stored;
  } cache_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_cmd = CMD_ADD;
  logic [TYPE_W-1:0] in_conn_type = '0;
  logic [KEY_W-1:0]  in_name_key = '0;
  logic              in_name_empty = 1'b0;
  logic [TIME_W-1:0] in_update_time = '0;
  logic [QUAL_W-1:0] in_quality_in = '0;
  logic              out_valid;
  logic              out_hit;
  logic [QUAL_W-1:0] out_quality_out;
  logic              out_stored;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TYPE_W-1:0] cfg_data = '0;

  entry_t            cache_rec [ENTRIES];
  bit                cache_live [ENTRIES];
  logic [TYPE_W-1:0] eth_code = ETH_TYPE_RESET;

  cache_result_t     pending_results [$];
  int                errors = 0;
  int                idle_count = 0;
  int                burst_left = 0;

  keyed_cache_oldest_eviction i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_conn_type    (in_conn_type),
    .in_name_key     (in_name_key),
    .in_name_empty   (in_name_empty),
    .in_update_time  (in_update_time),
    .in_quality_in   (in_quality_in),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_quality_out (out_quality_out),
    .out_stored      (out_stored),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic cache_result_t cache_apply(input logic cmd, input logic [TYPE_W-1:0] ctype,
                                                input logic [KEY_W-1:0] key, input logic empty,
                                                input logic [TIME_W-1:0] stamp,
                                                input logic [QUAL_W-1:0] qual);
    int            match_idx;
    int            used;
    int            victim;
    int            free_idx;
    cache_result_t r;
    r = '0;
    match_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_idx < 0 && cache_live[i] && cache_rec[i].conn_type == ctype &&
          cache_rec[i].name_key == key)
        match_idx = i;
    end
    if (cmd == CMD_LOOKUP) begin
      if (match_idx >= 0) begin
        r.hit     = 1'b1;
        r.quality = cache_rec[match_idx].quality;
      end
      return r;
    end
    if (empty && ctype != eth_code) return r;
    if (match_idx >= 0) cache_live[match_idx] = 1'b0;
    used = 0;
    for (int i = 0; i < ENTRIES; i++) if (cache_live[i]) used++;
    if (used == ENTRIES) begin
      victim = 0;
      for (int i = 1; i < ENTRIES; i++)
        if (cache_rec[i].upd_time < cache_rec[victim].upd_time) victim = i;
      cache_live[victim] = 1'b0;
    end
    free_idx = -1;
    for (int i = 0; i < ENTRIES; i++) if (free_idx < 0 && !cache_live[i]) free_idx = i;
    cache_live[free_idx] = 1'b1;
    cache_rec[free_idx].conn_type = ctype;
    cache_rec[free_idx].name_key  = key;
    cache_rec[free_idx].upd_time  = stamp;
    cache_rec[free_idx].quality   = qual;
    r.stored = 1'b1;
    return r;
  endfunction

  task automatic send_item(input logic cmd, input logic [TYPE_W-1:0] ctype,
                           input logic [KEY_W-1:0] key, input logic empty,
                           input logic [TIME_W-1:0] stamp, input logic [QUAL_W-1:0] qual);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_conn_type   <= ctype;
    in_name_key    <= key;
    in_name_empty  <= empty;
    in_update_time <= stamp;
    in_quality_in  <= qual;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(cache_apply(cmd, ctype, key, empty, stamp, qual));
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic write_eth_code(input logic [TYPE_W-1:0] code);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eth_code = code;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_directed_corners();
    send_item(CMD_LOOKUP, 4'h0, '0, 1'b0, '0, '0);
    pace();
    send_item(CMD_ADD, 4'h2, 64'h1, 1'b1, 32'h10, 64'hA5);
    pace();
    send_item(CMD_LOOKUP, 4'h2, 64'h1, 1'b1, '1, '1);
    pace();
    send_item(CMD_ADD, ETH_TYPE_RESET, '1, 1'b1, '1, '1);
    pace();
    send_item(CMD_LOOKUP, ETH_TYPE_RESET, '1, 1'b1, '0, '0);
    pace();
    send_item(CMD_ADD, 4'hF, '0, 1'b0, '0, '0);
    pace();
    for (int k = 1; k <= 6; k++) begin
      send_item(CMD_ADD, 4'h3, KEY_W'(k), 1'b0, 32'd5, QUAL_W'(k * 3));
      pace();
    end
    send_item(CMD_ADD, 4'h3, 64'h7, 1'b0, 32'd5, 64'h77);
    pace();
    send_item(CMD_LOOKUP, 4'hF, '0, 1'b0, '0, '0);
    pace();
    send_item(CMD_ADD, 4'h3, 64'h3, 1'b0, 32'd1, 64'hDEAD_BEEF_0123_4567);
    pace();
    send_item(CMD_LOOKUP, 4'h3, 64'h3, 1'b0, '0, '0);
    pace();
    send_item(CMD_ADD, 4'h3, 64'h8, 1'b0, 32'd5, 64'h88);
    pace();
    send_item(CMD_ADD, 4'h3, 64'h9, 1'b0, 32'd5, 64'h99);
    pace();
    send_item(CMD_LOOKUP, 4'h3, 64'h7, 1'b0, '0, '0);
    pace();
    send_item(CMD_LOOKUP, 4'h3, 64'h1, 1'b0, '0, '0);
    pace();
    send_item(CMD_LOOKUP, 4'h3, 64'h9, 1'b1, '0, '0);
    pace();
    send_item(CMD_LOOKUP, 4'h4, 64'h1, 1'b0, '0, '0);
  endtask

  task automatic test_register_extremes();
    write_eth_code(4'h0);
    send_item(CMD_ADD, 4'h0, 64'h55, 1'b1, 32'd100, 64'h5555);
    pace();
    send_item(CMD_ADD, 4'h1, 64'h56, 1'b1, 32'd100, 64'h5656);
    pace();
    send_item(CMD_LOOKUP, 4'h1, 64'h56, 1'b1, '0, '0);
    write_eth_code(4'hF);
    send_item(CMD_ADD, 4'hF, 64'h57, 1'b1, 32'd200, 64'h5757);
    pace();
    send_item(CMD_ADD, 4'h0, 64'h58, 1'b1, 32'd200, 64'h5858);
    pace();
    send_item(CMD_LOOKUP, 4'h0, 64'h55, 1'b1, '0, '0);
    pace();
    send_item(CMD_LOOKUP, 4'hF, 64'h57, 1'b0, '0, '0);
  endtask

  task automatic test_random_traffic();
    logic [KEY_W-1:0]  key_pool [16];
    logic [TYPE_W-1:0] type_pool [4];
    int                pool_n;
    int                stamp_ctr;
    bit                noise;
    logic              cmd;
    logic [TYPE_W-1:0] ctype;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
    stamp_ctr = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) write_eth_code(4'h0);
      else if (ph == 1) write_eth_code(4'hF);
      else write_eth_code(TYPE_W'($urandom_range(0, 15)));
      for (int i = 0; i < 16; i++) key_pool[i] = rand64();
      type_pool[0] = eth_code;
      for (int i = 1; i < 4; i++) type_pool[i] = TYPE_W'($urandom);
      pool_n = (ph % 2 == 1) ? $urandom_range(3, 6) : $urandom_range(9, 16);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        noise = ($urandom_range(0, 9) == 0);
        key   = noise ? rand64() : key_pool[$urandom_range(0, pool_n - 1)];
        ctype = noise ? TYPE_W'($urandom) : type_pool[$urandom_range(0, 3)];
        cmd   = ($urandom_range(0, 99) < 45) ? CMD_LOOKUP : CMD_ADD;
        case ($urandom_range(0, 2))
          0:       stamp = $urandom;
          1:       stamp = TIME_W'($urandom_range(0, 3));
          default: begin
            stamp_ctr++;
            stamp = TIME_W'(stamp_ctr);
          end
        endcase
        send_item(cmd, ctype, key, $urandom_range(0, 3) == 0, stamp, rand64());
        pace();
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      cache_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual hit %0d quality %h stored %0d", $time,
                 out_hit, out_quality_out, out_stored);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_hit !== exp_r.hit) begin
          errors++;
          $display("%0t: hit mismatch, expected %0d, actual %0d", $time, exp_r.hit, out_hit);
        end
        if (out_quality_out !== exp_r.quality) begin
          errors++;
          $display("%0t: quality_out mismatch, expected %h, actual %h", $time,
                   exp_r.quality, out_quality_out);
        end
        if (out_stored !== exp_r.stored) begin
          errors++;
          $display("%0t: stored mismatch, expected %0d, actual %0d", $time,
                   exp_r.stored, out_stored);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= IDLE_LIMIT) begin
        $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_register_extremes();
    test_random_traffic();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
